/* hw/rtl/pcse_pkg.sv */
// Shared types, codes and constants of the piecewise cubic spline evaluator.
package pcse_pkg;

   localparam int DEFAULT_MAX_SEGMENTS = 64;
   localparam int DEFAULT_X_FRAC_BITS  = 16;

   localparam int X_W        = 32;
   localparam int COEF_W     = 48;
   localparam int ACC_W      = 51;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REQ_WRITE_KNOT = 2'd0;
   localparam logic [1:0] REQ_WRITE_COEF = 2'd1;
   localparam logic [1:0] REQ_EVALUATE   = 2'd2;

   localparam logic [1:0] REGION_INSIDE = 2'd0;
   localparam logic [1:0] REGION_LEFT   = 2'd1;
   localparam logic [1:0] REGION_RIGHT  = 2'd2;

   localparam logic [1:0] DERIV_VALUE  = 2'd0;
   localparam logic [1:0] DERIV_FIRST  = 2'd1;
   localparam logic [1:0] DERIV_SECOND = 2'd2;
   localparam logic [1:0] DERIV_THIRD  = 2'd3;

   localparam logic CSR_SEGMENT_COUNT    = 1'b0;
   localparam logic CSR_DERIVATIVE_ORDER = 1'b1;

   localparam logic [6:0] SEGMENT_COUNT_RESET    = 7'd1;
   localparam logic [1:0] DERIVATIVE_ORDER_RESET = DERIV_VALUE;

   localparam logic signed [63:0] SAT_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_MIN    = -SAT_MAX - 64'sd1;
   localparam logic signed [63:0] PROD_LIMIT = 64'sh4000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [6:0]               slot;
      logic signed [X_W-1:0]    x_value;
      logic signed [COEF_W-1:0] coef_const;
      logic signed [COEF_W-1:0] coef_lin;
      logic signed [COEF_W-1:0] coef_quad;
      logic signed [COEF_W-1:0] coef_cube;
   } req_item_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] result_value;
      logic [1:0]               region;
      logic [5:0]               segment;
      logic                     saturated;
   } rsp_item_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_cube;
      logic signed [COEF_W-1:0] coef_quad;
      logic signed [COEF_W-1:0] coef_lin;
      logic signed [COEF_W-1:0] coef_const;
   } coef_set_type;

endpackage

/* hw/rtl/pcse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/piecewise_cubic_spline_evaluator.sv */
// Top level of the piecewise cubic spline evaluator: segment search and Horner pipeline.
//
// Evaluate items enter one per cycle while the response is not stalled, and each
// produces one result. The search has LEVELS = clog2(MAX_SEGMENTS) levels, each
// registered and reading its own pair of knot RAM copies; then come the registered
// coefficient RAM read, the registered forming of the derivative coefficients, the
// Horner steps (partial products, round and shift, clamp/add/saturate, each
// registered) and the output register. Knot and coefficient write items are held
// off until no evaluate item is left in the search, fetch or Horner stages and
// are then taken; type three items are dropped. Table entries hold no reset
// value and must be written before they are used.
module piecewise_cubic_spline_evaluator #(
   parameter int MAX_SEGMENTS = pcse_pkg::DEFAULT_MAX_SEGMENTS,
   parameter int X_FRAC_BITS  = pcse_pkg::DEFAULT_X_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pcse_pkg::req_item_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pcse_pkg::rsp_item_type                rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pcse_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [pcse_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [pcse_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import pcse_pkg::*;

   localparam int IW     = $clog2(MAX_SEGMENTS + 1);
   localparam int CAW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int LEVELS = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int PW     = ACC_W + 32;
   localparam int HSTAGES = 10;

   localparam logic signed [PW-1:0] ROUND_BIAS =
      PW'((65'(1) << X_FRAC_BITS) >> 1);
   localparam logic signed [PW-1:0] CLAMP_HI = PW'(PROD_LIMIT);
   localparam logic signed [PW-1:0] CLAMP_LO = -CLAMP_HI;

   typedef struct packed {
      logic                  valid;
      logic signed [X_W-1:0] x;
      logic [IW-1:0]         lo;
      logic [IW-1:0]         hi1;
      logic                  done;
      logic [1:0]            region;
   } search_type;

   typedef struct packed {
      logic                  valid;
      logic signed [X_W-1:0] x;
      logic [1:0]            region;
      logic [IW-1:0]         seg;
   } fetch_type;

   typedef struct packed {
      logic                    valid;
      logic signed [X_W-1:0]   x;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] e2;
      logic signed [ACC_W-1:0] e1;
      logic signed [ACC_W-1:0] e0;
      logic [1:0]              region;
      logic [5:0]              segment;
      logic                    clip;
      logic signed [64:0]      p_lo;
      logic signed [ACC_W-1:0] p_hi;
      logic signed [PW-1:0]    prod;
   } horner_type;

   // configuration registers
   logic [6:0] seg_count_ff;
   logic [1:0] deriv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEGMENT_COUNT_RESET;
         deriv_ff     <= DERIVATIVE_ORDER_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            CSR_SEGMENT_COUNT:    seg_count_ff <= pwdata[6:0];
            CSR_DERIVATIVE_ORDER: deriv_ff     <= pwdata[1:0];
            default:              seg_count_ff <= seg_count_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_SEGMENT_COUNT:    prdata = CSR_DATA_W'(seg_count_ff);
         CSR_DERIVATIVE_ORDER: prdata = CSR_DATA_W'(deriv_ff);
         default:              prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // segment count clamped to 1..MAX_SEGMENTS
   logic [31:0]   n_wide;
   logic [IW-1:0] n_eff;
   logic [IW-1:0] n_last;

   always_comb begin
      if (seg_count_ff == '0) begin
         n_wide = 32'd1;
      end else if (32'(seg_count_ff) > 32'(MAX_SEGMENTS)) begin
         n_wide = 32'(MAX_SEGMENTS);
      end else begin
         n_wide = 32'(seg_count_ff);
      end
      n_eff  = IW'(n_wide);
      n_last = IW'(n_wide - 32'd1);
   end

   function automatic logic [IW-1:0] mid_of(input logic [IW-1:0] lo, input logic [IW-1:0] hi1);
      logic [IW:0] sum;
      sum = {1'b0, lo} + {1'b0, hi1};
      if (sum == '0) begin
         return '0;
      end
      sum = sum - 1'b1;
      return sum[IW:1];
   endfunction

   function automatic logic [IW-1:0] mid_next(input logic [IW-1:0] lo, input logic [IW-1:0] hi1);
      logic [IW:0] nxt;
      nxt = {1'b0, mid_of(lo, hi1)} + 1'b1;
      return nxt[IW-1:0];
   endfunction

   // pipeline control
   search_type srch_ff [LEVELS+1];
   search_type srch_in [LEVELS+1];
   fetch_type  fetch_ff;
   fetch_type  fetch_in;
   horner_type hstage_ff [HSTAGES];
   horner_type hstage_in [HSTAGES];
   logic       rsp_valid_ff;
   rsp_item_type rsp_data_ff;
   rsp_item_type rsp_data_in;

   logic pipe_stall;
   logic advance;
   logic busy;
   logic is_write;
   logic accept;

   assign pipe_stall = rsp_valid_ff && rsp_stall;
   assign advance    = !pipe_stall;
   assign is_write   = (req_data.req_type == REQ_WRITE_KNOT) ||
                       (req_data.req_type == REQ_WRITE_COEF);

   always_comb begin
      busy = fetch_ff.valid;
      for (int i = 0; i <= LEVELS; i++) begin
         busy = busy | srch_ff[i].valid;
      end
      for (int i = 0; i < HSTAGES; i++) begin
         busy = busy | hstage_ff[i].valid;
      end
   end

   assign req_stall = pipe_stall || (req_valid && is_write && busy);
   assign accept    = req_valid && !req_stall;

   // table writes
   logic [31:0]      slot_wide;
   logic             knot_we;
   logic             coef_we;
   logic             left_we;
   logic             right_we;
   logic [IW-1:0]    knot_waddr;
   logic [CAW-1:0]   coef_waddr;
   coef_set_type     coef_wdata;
   coef_set_type     coef_rd;

   assign slot_wide  = 32'(req_data.slot);
   assign knot_we    = accept && (req_data.req_type == REQ_WRITE_KNOT) &&
                       (slot_wide <= 32'(MAX_SEGMENTS));
   assign coef_we    = accept && (req_data.req_type == REQ_WRITE_COEF) &&
                       (slot_wide >= 32'd1) && (slot_wide <= 32'(MAX_SEGMENTS));
   assign left_we    = accept && (req_data.req_type == REQ_WRITE_COEF) && (slot_wide == 32'd0);
   assign right_we   = accept && (req_data.req_type == REQ_WRITE_COEF) &&
                       (slot_wide == 32'(MAX_SEGMENTS + 1));
   assign knot_waddr = IW'(slot_wide);
   assign coef_waddr = CAW'(slot_wide - 32'd1);

   always_comb begin
      coef_wdata.coef_cube  = req_data.coef_cube;
      coef_wdata.coef_quad  = req_data.coef_quad;
      coef_wdata.coef_lin   = req_data.coef_lin;
      coef_wdata.coef_const = req_data.coef_const;
   end

   logic signed [COEF_W-1:0] left_c0_ff;
   logic signed [COEF_W-1:0] left_c1_ff;
   logic signed [COEF_W-1:0] right_c0_ff;
   logic signed [COEF_W-1:0] right_c1_ff;

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_c0_ff <= req_data.coef_const;
         left_c1_ff <= req_data.coef_lin;
      end
      if (right_we) begin
         right_c0_ff <= req_data.coef_const;
         right_c1_ff <= req_data.coef_lin;
      end
   end

   // entry
   always_comb begin
      srch_in[0].valid  = accept && (req_data.req_type == REQ_EVALUATE);
      srch_in[0].x      = req_data.x_value;
      srch_in[0].lo     = '0;
      srch_in[0].hi1    = n_eff;
      srch_in[0].done   = 1'b0;
      srch_in[0].region = REGION_INSIDE;
   end

   logic [X_W-1:0] edge_lo_rd;
   logic [X_W-1:0] edge_hi_rd;

   pcse_ram #(.WIDTH(X_W), .DEPTH(MAX_SEGMENTS + 1)) u_knot_first (
      .clock   (clock),
      .wr_en   (knot_we),
      .wr_addr (knot_waddr),
      .wr_data (req_data.x_value),
      .rd_en   (advance),
      .rd_addr ('0),
      .rd_data (edge_lo_rd)
   );

   pcse_ram #(.WIDTH(X_W), .DEPTH(MAX_SEGMENTS + 1)) u_knot_last (
      .clock   (clock),
      .wr_en   (knot_we),
      .wr_addr (knot_waddr),
      .wr_data (req_data.x_value),
      .rd_en   (advance),
      .rd_addr (n_eff),
      .rd_data (edge_hi_rd)
   );

   // binary search, one level per stage
   logic [X_W-1:0] knot_a_rd [LEVELS];
   logic [X_W-1:0] knot_b_rd [LEVELS];

   for (genvar i = 0; i < LEVELS; i++) begin : g_level
      pcse_ram #(.WIDTH(X_W), .DEPTH(MAX_SEGMENTS + 1)) u_knot_a (
         .clock   (clock),
         .wr_en   (knot_we),
         .wr_addr (knot_waddr),
         .wr_data (req_data.x_value),
         .rd_en   (advance),
         .rd_addr (mid_of(srch_in[i].lo, srch_in[i].hi1)),
         .rd_data (knot_a_rd[i])
      );

      pcse_ram #(.WIDTH(X_W), .DEPTH(MAX_SEGMENTS + 1)) u_knot_b (
         .clock   (clock),
         .wr_en   (knot_we),
         .wr_addr (knot_waddr),
         .wr_data (req_data.x_value),
         .rd_en   (advance),
         .rd_addr (mid_next(srch_in[i].lo, srch_in[i].hi1)),
         .rd_data (knot_b_rd[i])
      );

      always_comb begin
         logic [IW-1:0]         m;
         logic [IW:0]           m_inc;
         logic signed [X_W-1:0] ka;
         logic signed [X_W-1:0] kb;
         srch_in[i+1] = srch_ff[i];
         m     = mid_of(srch_ff[i].lo, srch_ff[i].hi1);
         m_inc = {1'b0, m} + 1'b1;
         ka    = $signed(knot_a_rd[i]);
         kb    = $signed(knot_b_rd[i]);
         if (!srch_ff[i].done &&
             (({1'b0, srch_ff[i].lo} + 1'b1) < {1'b0, srch_ff[i].hi1})) begin
            if (srch_ff[i].x < ka) begin
               srch_in[i+1].hi1 = m;
            end else if (srch_ff[i].x > kb) begin
               srch_in[i+1].lo = m_inc[IW-1:0];
            end else begin
               srch_in[i+1].lo   = m;
               srch_in[i+1].done = 1'b1;
            end
         end
         if (i == 0) begin
            if (srch_ff[i].x < $signed(edge_lo_rd)) begin
               srch_in[i+1].region = REGION_LEFT;
            end else if (srch_ff[i].x > $signed(edge_hi_rd)) begin
               srch_in[i+1].region = REGION_RIGHT;
            end else begin
               srch_in[i+1].region = REGION_INSIDE;
            end
         end
      end
   end

   // coefficient fetch
   logic [IW-1:0] lo_final;

   always_comb begin
      lo_final = (srch_ff[LEVELS].lo > n_last) ? n_last : srch_ff[LEVELS].lo;
      fetch_in.valid  = srch_ff[LEVELS].valid;
      fetch_in.x      = srch_ff[LEVELS].x;
      fetch_in.region = srch_ff[LEVELS].region;
      fetch_in.seg    = lo_final;
   end

   pcse_ram #(.WIDTH($bits(coef_set_type)), .DEPTH(MAX_SEGMENTS)) u_coef (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_en   (advance),
      .rd_addr (CAW'(lo_final)),
      .rd_data (coef_rd)
   );

   // derivative coefficients
   always_comb begin
      logic signed [ACC_W-1:0] c0;
      logic signed [ACC_W-1:0] c1;
      logic signed [ACC_W-1:0] c2;
      logic signed [ACC_W-1:0] c3;
      logic signed [ACC_W-1:0] c2x2;
      logic signed [ACC_W-1:0] c3x3;
      logic signed [ACC_W-1:0] c3x6;
      case (fetch_ff.region)
         REGION_LEFT: begin
            c0 = ACC_W'(left_c0_ff);
            c1 = ACC_W'(left_c1_ff);
            c2 = '0;
            c3 = '0;
         end
         REGION_RIGHT: begin
            c0 = ACC_W'(right_c0_ff);
            c1 = ACC_W'(right_c1_ff);
            c2 = '0;
            c3 = '0;
         end
         default: begin
            c0 = ACC_W'(coef_rd.coef_const);
            c1 = ACC_W'(coef_rd.coef_lin);
            c2 = ACC_W'(coef_rd.coef_quad);
            c3 = ACC_W'(coef_rd.coef_cube);
         end
      endcase
      c2x2 = c2 <<< 1;
      c3x3 = c3 + (c3 <<< 1);
      c3x6 = c3x3 <<< 1;

      hstage_in[0]         = '0;
      hstage_in[0].valid   = fetch_ff.valid;
      hstage_in[0].x       = fetch_ff.x;
      hstage_in[0].region  = fetch_ff.region;
      hstage_in[0].segment = (fetch_ff.region == REGION_INSIDE) ? 6'(fetch_ff.seg) : 6'd0;
      hstage_in[0].clip    = 1'b0;
      case (deriv_ff)
         DERIV_VALUE: begin
            hstage_in[0].acc = c3;
            hstage_in[0].e2  = c2;
            hstage_in[0].e1  = c1;
            hstage_in[0].e0  = c0;
         end
         DERIV_FIRST: begin
            hstage_in[0].acc = c3x3;
            hstage_in[0].e2  = '0;
            hstage_in[0].e1  = c2x2;
            hstage_in[0].e0  = c1;
         end
         DERIV_SECOND: begin
            hstage_in[0].acc = c3x6;
            hstage_in[0].e2  = '0;
            hstage_in[0].e1  = '0;
            hstage_in[0].e0  = c2x2;
         end
         default: begin
            hstage_in[0].acc = c3x6;
            hstage_in[0].e2  = '0;
            hstage_in[0].e1  = '0;
            hstage_in[0].e0  = '0;
         end
      endcase
   end

   // Horner steps: multiply, round/shift, clamp/add/saturate
   for (genvar s = 0; s < 3; s++) begin : g_step
      always_comb begin
         hstage_in[3*s+1]      = hstage_ff[3*s];
         hstage_in[3*s+1].p_lo = $signed({1'b0, hstage_ff[3*s].acc[31:0]}) * hstage_ff[3*s].x;
         hstage_in[3*s+1].p_hi = $signed(hstage_ff[3*s].acc[ACC_W-1:32]) * hstage_ff[3*s].x;
      end

      always_comb begin
         logic signed [PW-1:0] full;
         hstage_in[3*s+2] = hstage_ff[3*s+1];
         full = (PW'(hstage_ff[3*s+1].p_hi) <<< 32) + PW'(hstage_ff[3*s+1].p_lo) + ROUND_BIAS;
         hstage_in[3*s+2].prod = full >>> X_FRAC_BITS;
      end

      always_comb begin
         logic signed [PW-1:0]    clamped;
         logic signed [63:0]      sum;
         logic signed [63:0]      sat;
         logic signed [ACC_W-1:0] ej;
         logic                    over;
         hstage_in[3*s+3] = hstage_ff[3*s+2];
         ej = (s == 0) ? hstage_ff[3*s+2].e2 :
              (s == 1) ? hstage_ff[3*s+2].e1 : hstage_ff[3*s+2].e0;
         if (hstage_ff[3*s+2].prod > CLAMP_HI) begin
            clamped = CLAMP_HI;
         end else if (hstage_ff[3*s+2].prod < CLAMP_LO) begin
            clamped = CLAMP_LO;
         end else begin
            clamped = hstage_ff[3*s+2].prod;
         end
         sum  = 64'(clamped) + 64'(ej);
         over = 1'b0;
         if (sum > SAT_MAX) begin
            sat  = SAT_MAX;
            over = 1'b1;
         end else if (sum < SAT_MIN) begin
            sat  = SAT_MIN;
            over = 1'b1;
         end else begin
            sat = sum;
         end
         if (32'(s) >= 32'(deriv_ff)) begin
            hstage_in[3*s+3].acc  = ACC_W'(sat);
            hstage_in[3*s+3].clip = hstage_ff[3*s+2].clip | over;
         end
      end
   end

   // final saturation
   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic                    over;
      acc  = hstage_ff[HSTAGES-1].acc;
      over = 1'b0;
      if (acc > SAT_MAX) begin
         rsp_data_in.result_value = COEF_W'(SAT_MAX);
         over = 1'b1;
      end else if (acc < SAT_MIN) begin
         rsp_data_in.result_value = COEF_W'(SAT_MIN);
         over = 1'b1;
      end else begin
         rsp_data_in.result_value = COEF_W'(acc);
      end
      rsp_data_in.region    = hstage_ff[HSTAGES-1].region;
      rsp_data_in.segment   = hstage_ff[HSTAGES-1].segment;
      rsp_data_in.saturated = hstage_ff[HSTAGES-1].clip | over;
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LEVELS; i++) begin
            srch_ff[i].valid <= 1'b0;
         end
         fetch_ff.valid <= 1'b0;
         for (int i = 0; i < HSTAGES; i++) begin
            hstage_ff[i].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i <= LEVELS; i++) begin
            srch_ff[i] <= srch_in[i];
         end
         fetch_ff <= fetch_in;
         for (int i = 0; i < HSTAGES; i++) begin
            hstage_ff[i] <= hstage_in[i];
         end
         rsp_valid_ff <= hstage_ff[HSTAGES-1].valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
